FILE: src/sliding_window_moving_average_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving average block
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MOVING_AVERAGE_TOP_MACROS_SVH
`define SLIDING_WINDOW_MOVING_AVERAGE_TOP_MACROS_SVH

// same-cycle implication
`define SWMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/swma_pkg.sv
// ----------------------------------------------------------------------------
// Moving average package
// Field widths and default sizing for the sliding window averager.
// ----------------------------------------------------------------------------
package swma_pkg;

    localparam int SAMPLE_W      = 56;
    localparam int LEN_W         = 9;
    localparam int SUM_W         = 64;
    localparam int DEF_MAX_SLOTS = 256;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [LEN_W-1:0]    t_len;

endpackage

FILE: src/sliding_window_moving_average_top.sv
// Operation: each accepted request takes one ring read, a subtract, an add,
//   a set-up step, 64 divider steps and a load step that waits while a held result is stalled.
// Throughput: o_stall holds off a new request until the last result is loaded;
//   the bit-serial restoring divider takes one quotient bit of the 64-bit sum per cycle.
// Reset (synchronous, active low): window length 16, window empty; ring
//   contents are not cleared, and an old slot value is only used once rewritten.
// ----------------------------------------------------------------------------
// Sliding window moving average
// Ring of recent samples with an exact running sum, divided by the stored
// count through a bit-serial shift-subtract divider.
// ----------------------------------------------------------------------------
module sliding_window_moving_average_top #(
    parameter int MAX_SLOTS = swma_pkg::DEF_MAX_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [swma_pkg::LEN_W-1:0]    i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [swma_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [swma_pkg::SAMPLE_W-1:0] o_average,
    output logic                          o_window_full
);
    import swma_pkg::*;

    localparam int PTR_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int EXT_W   = SUM_W - SAMPLE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SUB  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    t_sample r_ring [MAX_SLOTS];

    logic [2:0]       r_state;
    t_len             r_window_length;
    logic [PTR_W-1:0] r_wp;
    t_len             r_fill_count;
    t_sum             r_sum;
    t_sample          r_sample;
    t_sample          r_old;
    logic             r_was_full;
    t_len             r_divisor;
    logic             r_full_flag;
    logic             r_neg;
    t_sum             r_quo;
    t_len             r_rem;
    logic [STEP_W-1:0] r_step;
    logic             r_out_valid;
    t_sample          r_average;
    logic             r_window_full;

    t_len             eff_len;
    t_len             wp_inc;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   trial_diff;
    t_sum             quo_signed;
    logic             out_free;

    always_comb begin
        if (r_window_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_window_length > LEN_W'(MAX_SLOTS)) begin
            eff_len = LEN_W'(MAX_SLOTS);
        end else begin
            eff_len = r_window_length;
        end
    end

    assign wp_inc     = LEN_W'(r_wp) + LEN_W'(1);
    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_diff = trial - {1'b0, r_divisor};
    assign quo_signed = r_neg ? (t_sum'(0) - r_quo) : r_quo;
    assign out_free   = !r_out_valid || !i_stall;

    // ring port: read oldest and write newest at the same slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_old        <= r_ring[r_wp];
            r_ring[r_wp] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_length <= LEN_RESET;
            r_wp            <= '0;
            r_fill_count    <= '0;
            r_sum           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_window_length <= i_cfg_wr_data;
                r_wp            <= '0;
                r_fill_count    <= '0;
                r_sum           <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_was_full <= (r_fill_count >= eff_len);
                    r_wp       <= (wp_inc >= eff_len) ? '0 : r_wp + PTR_W'(1);
                    r_state    <= S_SUB;
                end
                S_SUB: begin
                    if (r_was_full) begin
                        r_sum <= r_sum - {{EXT_W{r_old[SAMPLE_W-1]}}, r_old};
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum <= r_sum + {{EXT_W{r_sample[SAMPLE_W-1]}}, r_sample};
                    if (r_was_full) begin
                        r_divisor   <= eff_len;
                        r_full_flag <= 1'b1;
                    end else begin
                        r_fill_count <= r_fill_count + LEN_W'(1);
                        r_divisor    <= r_fill_count + LEN_W'(1);
                        r_full_flag  <= (r_fill_count + LEN_W'(1) >= eff_len);
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_quo   <= r_sum[SUM_W-1] ? (t_sum'(0) - r_sum) : r_sum;
                    r_rem   <= '0;
                    r_step  <= '1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // shift in one dividend bit, subtract when it fits
                    if (!trial_diff[LEN_W]) begin
                        r_rem <= trial_diff[LEN_W-1:0];
                        r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= trial[LEN_W-1:0];
                        r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                    end
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_average     <= quo_signed[SAMPLE_W-1:0];
                        r_window_full <= r_full_flag;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_average     = r_average;
    assign o_window_full = r_window_full;

`include "sliding_window_moving_average_top_macros.svh"

    `SWMA_ASSERT_SAME(a_fill_bound, r_state == S_IDLE, r_fill_count <= eff_len, "fill count beyond window")
    `SWMA_ASSERT_SAME(a_wp_bound, r_state == S_IDLE, LEN_W'(r_wp) < eff_len, "write pointer beyond window")
    `SWMA_ASSERT_NEXT(a_done_load, (r_state == S_DONE) && out_free, r_out_valid && (r_state == S_IDLE), "result not loaded")

endmodule

FILE: tb/swma_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moving average result checker
// Watches the request, result and register write ports of the averager,
// predicts each average and full flag from an exact windowed sum, and
// compares every accepted result against the oldest prediction in order.
// ----------------------------------------------------------------------------
module swma_result_checker
    import swma_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_wr_en,
    input  t_len    i_cfg_wr_data,
    input  logic    i_valid,
    input  logic    o_stall,
    input  t_sample i_sample,
    input  logic    o_valid,
    input  logic    i_stall,
    input  t_sample o_average,
    input  logic    o_window_full,
    output int      o_fail_count,
    output int      o_pending
);

    typedef struct packed {
        t_sample average;
        logic    window_full;
    } t_avg_result;

    t_avg_result     expected_averages[$];
    t_sample         window_ring [MAX_SLOTS];
    longint          window_sum;
    int unsigned     slot_ptr;
    int unsigned     stored_count;
    t_len            window_len;
    int              fails = 0;

    function automatic void clear_window();
        slot_ptr     = 0;
        stored_count = 0;
        window_sum   = 0;
    endfunction

    function automatic t_avg_result predict_average(input t_sample smp);
        int unsigned span;
        int unsigned slot;
        int unsigned divisor;
        longint      value;
        t_avg_result res;
        span  = (window_len == 0) ? 1 : ((window_len > MAX_SLOTS) ? MAX_SLOTS : window_len);
        value = longint'($signed(smp));
        slot  = slot_ptr % MAX_SLOTS;
        if (stored_count < span) begin
            window_sum   = window_sum + value;
            stored_count = stored_count + 1;
            divisor      = stored_count;
        end else begin
            window_sum = window_sum - longint'($signed(window_ring[slot])) + value;
            divisor    = span;
        end
        window_ring[slot] = smp;
        slot_ptr          = (slot + 1 >= span) ? 0 : slot + 1;
        res.average       = t_sample'(window_sum / longint'(divisor));
        res.window_full   = (stored_count >= span);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_avg_result want;
        if (!i_rst_n) begin
            window_len = LEN_RESET;
            clear_window();
            expected_averages.delete();
        end else begin
            if (i_cfg_wr_en) begin
                window_len = i_cfg_wr_data;
                clear_window();
            end
            if (o_valid && !i_stall) begin
                if (expected_averages.size() == 0) begin
                    $error("result with no request outstanding: average %0d window_full %0b",
                           $signed(o_average), o_window_full);
                    fails++;
                end else begin
                    want = expected_averages.pop_front();
                    if (o_average !== want.average) begin
                        $error("average: expected %0d, actual %0d",
                               $signed(want.average), $signed(o_average));
                        fails++;
                    end
                    if (o_window_full !== want.window_full) begin
                        $error("window_full: expected %0b, actual %0b",
                               want.window_full, o_window_full);
                        fails++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                expected_averages.push_back(predict_average(i_sample));
            end
        end
        o_pending    <= expected_averages.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb_sliding_window_moving_average_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moving average testbench
// Drives directed and random samples through a range of window lengths,
// including zero and saturating lengths, with bursty requests and a
// shifting result stall pattern; the checker beside the block compares.
// ----------------------------------------------------------------------------
module tb_sliding_window_moving_average_top;
    import swma_pkg::*;

    localparam int      RANDOM_ITEMS   = 800;
    localparam int      WATCHDOG_LIMIT = 1000;
    localparam int      DRAIN_CYCLES   = 80;
    localparam t_sample SAMPLE_MAX     = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN     = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} t_stall_mode;

    typedef enum int {MIX_ANY, MIX_ALL_MAX, MIX_ALL_MIN} t_sample_mix;

    logic    i_clk         = 1'b0;
    logic    i_rst_n       = 1'b0;
    logic    i_cfg_wr_en   = 1'b0;
    t_len    i_cfg_wr_data = '0;
    logic    i_valid       = 1'b0;
    logic    o_stall;
    t_sample i_sample      = '0;
    logic    o_valid;
    logic    i_stall       = 1'b0;
    t_sample o_average;
    logic    o_window_full;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          burst_left  = 4;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_phase = 0;
    int          stall_run   = 0;

    always #5 i_clk = ~i_clk;

    sliding_window_moving_average_top #(
        .MAX_SLOTS(DEF_MAX_SLOTS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_average    (o_average),
        .o_window_full(o_window_full)
    );

    swma_result_checker #(
        .MAX_SLOTS(DEF_MAX_SLOTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_average    (o_average),
        .o_window_full(o_window_full),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result stall: switch between no stall, random stall and long runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_phase <= 0;
            stall_run   <= 0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode  <= t_stall_mode'($urandom_range(0, 2));
                stall_phase <= $urandom_range(50, 500);
            end else begin
                stall_phase <= stall_phase - 1;
            end
            case (stall_mode)
                STALL_NONE: begin
                    i_stall <= 1'b0;
                end
                STALL_RANDOM: begin
                    i_stall <= ($urandom_range(0, 2) == 0);
                end
                default: begin
                    if (stall_run == 0) begin
                        i_stall   <= ~i_stall;
                        stall_run <= $urandom_range(1, 16);
                    end else begin
                        stall_run <= stall_run - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(input t_sample smp);
        int gap;
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 30);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // drop the request and hold until every result is back
    task automatic settle();
        if (i_valid) i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_window_length(input t_len len);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic t_sample random_sample(input t_sample_mix mix);
        if (mix == MIX_ALL_MAX) return SAMPLE_MAX;
        if (mix == MIX_ALL_MIN) return SAMPLE_MIN;
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return ($urandom_range(0, 1) == 0) ? t_sample'(0) : t_sample'(-1);
            3:       return t_sample'(int'($urandom_range(0, 200)) - 100);
            default: return t_sample'({$urandom, $urandom});
        endcase
    endfunction

    initial begin
        int          sent;
        int          items;
        int unsigned span;
        t_len        len;
        t_sample_mix mix;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window length from reset
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(t_sample'(0));
        send_sample(t_sample'(-1));
        send_sample(t_sample'(1));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        write_window_length(t_len'(1));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(t_sample'(-5));

        // zero length behaves as one
        write_window_length(t_len'(0));
        send_sample(t_sample'(7));
        send_sample(t_sample'(-7));

        write_window_length(t_len'(2));
        send_sample(t_sample'(-1));
        send_sample(t_sample'(-2));
        send_sample(t_sample'(3));
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);

        // lengths past the ring size saturate
        write_window_length(t_len'(511));
        send_sample(SAMPLE_MAX);
        send_sample(t_sample'(-1));

        write_window_length(t_len'(DEF_MAX_SLOTS));
        send_sample(SAMPLE_MIN);
        send_sample(t_sample'(1));

        write_window_length(t_len'(3));
        send_sample(t_sample'(5));
        send_sample(t_sample'(-9));
        send_sample(t_sample'(4));

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 15))
                0:       len = t_len'(0);
                1:       len = t_len'(1);
                2:       len = t_len'(DEF_MAX_SLOTS);
                3:       len = t_len'($urandom_range(DEF_MAX_SLOTS + 1, 511));
                4:       len = t_len'($urandom_range(65, DEF_MAX_SLOTS - 1));
                default: len = t_len'($urandom_range(2, 40));
            endcase
            span = (len == 0) ? 1 : ((len > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS : len);
            items = (span > 64) ? span + $urandom_range(1, 40)
                                : $urandom_range(1, 3) * span + $urandom_range(0, 12);
            if (items > RANDOM_ITEMS - sent) items = RANDOM_ITEMS - sent;
            case ($urandom_range(0, 7))
                0:       mix = MIX_ALL_MAX;
                1:       mix = MIX_ALL_MIN;
                default: mix = MIX_ANY;
            endcase
            write_window_length(len);
            repeat (items) begin
                send_sample(random_sample(mix));
                sent++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/swma_pkg.sv
src/sliding_window_moving_average_top.sv
tb/swma_result_checker.sv
tb/tb_sliding_window_moving_average_top.sv
